// ===== hw/rtl/ffcrc_pkg.sv =====
// Shared constants and types for the fixed-frame CRC-16 frame checker.
package ffcrc_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int POS_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [BYTE_W-1:0] LOW_BYTE = 8'hFF;

    // byte positions within a frame
    localparam logic [POS_W-1:0] POS_HEADER_HI = 4'd0;
    localparam logic [POS_W-1:0] POS_HEADER_LO = 4'd1;
    localparam logic [POS_W-1:0] POS_SOURCE    = 4'd2;
    localparam logic [POS_W-1:0] POS_DEST      = 4'd3;
    localparam logic [POS_W-1:0] POS_CMD_LO    = 4'd5;
    localparam logic [POS_W-1:0] POS_TAIL_HI   = 4'd8;
    localparam logic [POS_W-1:0] POS_TAIL_LO   = 4'd9;
    localparam logic [POS_W-1:0] POS_CRC_HI    = 4'd10;
    localparam logic [POS_W-1:0] FRAME_LAST    = 4'd11;
    localparam logic [POS_W-1:0] POS_CRC_END   = POS_TAIL_LO;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_ID = 2'd3;

    typedef enum logic [2:0] {
        ERR_OK     = 3'd0,
        ERR_HEADER = 3'd1,
        ERR_DEST   = 3'd2,
        ERR_TAIL   = 3'd3,
        ERR_CRC    = 3'd4
    } err_code_t;

endpackage

// ===== hw/rtl/ffcrc_crc_byte.sv =====
// One unrolled CRC-16/MODBUS byte step (reflected, LSB first).
module ffcrc_crc_byte (
    input  logic [ffcrc_pkg::WORD_W-1:0] crc_in,
    input  logic [ffcrc_pkg::BYTE_W-1:0] data_in,
    output logic [ffcrc_pkg::WORD_W-1:0] crc_out
);

    always_comb begin
        logic [ffcrc_pkg::WORD_W-1:0] c;
        c = crc_in ^ {{(ffcrc_pkg::WORD_W-ffcrc_pkg::BYTE_W){1'b0}}, data_in};
        for (int k = 0; k < ffcrc_pkg::BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ ffcrc_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

// ===== hw/rtl/fixed_frame_crc16_checker.sv =====
// Fixed-frame CRC-16 checker: 12-byte frames in, one verdict per frame out.
//
// Takes one frame byte per beat and accepts a new beat every clock cycle while no held verdict stalls.
// Each byte passes through an input register, one unrolled CRC-16/MODBUS
// byte step plus the field compares, and a result register, so the verdict
// is registered once the twelfth byte moves on from the input register. The result register
// holds a verdict while the sink stalls; input flow pauses only when a
// verdict is held and the byte in the input register is waiting to move on.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata; the user must write
// them only while no frame is in progress, which the block itself does not enforce.
module fixed_frame_crc16_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ffcrc_pkg::BYTE_W-1:0]       s_rx_byte,
    input  logic                               s_frame_start,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_frame_ok,
    output logic [2:0]                         m_error_code,
    output logic [ffcrc_pkg::BYTE_W-1:0]       m_source_id,
    output logic                               m_command_valid,
    output logic [ffcrc_pkg::BYTE_W-1:0]       m_command_value,
    input  logic                               cfg_we,
    input  logic [ffcrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ffcrc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [ffcrc_pkg::WORD_W-1:0] header_word_reg;
    logic [ffcrc_pkg::WORD_W-1:0] tail_word_reg;
    logic [ffcrc_pkg::BYTE_W-1:0] own_id_reg;
    logic [ffcrc_pkg::BYTE_W-1:0] main_id_reg;

    logic                         in_valid_reg;
    logic [ffcrc_pkg::BYTE_W-1:0] in_byte_reg;
    logic                         in_start_reg;

    logic [ffcrc_pkg::POS_W-1:0]  pos_reg,  pos_next;
    logic [ffcrc_pkg::WORD_W-1:0] crc_reg,  crc_next;
    logic [ffcrc_pkg::BYTE_W-1:0] hold_reg, hold_next;
    ffcrc_pkg::err_code_t         err_reg,  err_next;
    logic [ffcrc_pkg::BYTE_W-1:0] src_reg,  src_next;
    logic [ffcrc_pkg::BYTE_W-1:0] cmd_reg,  cmd_next;

    logic                         m_valid_reg;
    logic                         ok_reg;
    ffcrc_pkg::err_code_t         code_reg;
    logic [ffcrc_pkg::BYTE_W-1:0] src_out_reg;
    logic                         cmd_ok_reg;
    logic [ffcrc_pkg::BYTE_W-1:0] cmd_out_reg;

    logic                         restart;
    logic [ffcrc_pkg::POS_W-1:0]  pos;
    logic [ffcrc_pkg::WORD_W-1:0] crc_base;
    logic [ffcrc_pkg::WORD_W-1:0] crc_step;
    logic [ffcrc_pkg::BYTE_W-1:0] hold_base;
    ffcrc_pkg::err_code_t         err_base;
    logic [ffcrc_pkg::BYTE_W-1:0] src_base;
    logic [ffcrc_pkg::BYTE_W-1:0] cmd_base;
    logic [ffcrc_pkg::WORD_W-1:0] word;
    logic                         hit;
    ffcrc_pkg::err_code_t         hit_code;
    ffcrc_pkg::err_code_t         err_new;
    logic                         last;
    logic                         ok;
    logic                         cmd_ok;
    logic                         work_fire;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_word_reg <= '0;
            tail_word_reg   <= '0;
            own_id_reg      <= '0;
            main_id_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ffcrc_pkg::CFG_HEADER:  header_word_reg <= cfg_wdata;
                ffcrc_pkg::CFG_TAIL:    tail_word_reg   <= cfg_wdata;
                ffcrc_pkg::CFG_OWN_ID:  own_id_reg      <= cfg_wdata[ffcrc_pkg::BYTE_W-1:0];
                ffcrc_pkg::CFG_MAIN_ID: main_id_reg     <= cfg_wdata[ffcrc_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign work_fire = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || work_fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_rx_byte;
            in_start_reg <= s_frame_start;
        end
    end

    // frame state seen by this byte
    assign restart   = in_start_reg || (pos_reg > ffcrc_pkg::FRAME_LAST);
    assign pos       = restart ? ffcrc_pkg::POS_HEADER_HI : pos_reg;
    assign crc_base  = restart ? ffcrc_pkg::CRC_INIT : crc_reg;
    assign hold_base = restart ? '0 : hold_reg;
    assign err_base  = restart ? ffcrc_pkg::ERR_OK : err_reg;
    assign src_base  = restart ? '0 : src_reg;
    assign cmd_base  = restart ? '0 : cmd_reg;
    assign word      = {hold_base, in_byte_reg};
    assign last      = (pos == ffcrc_pkg::FRAME_LAST);

    ffcrc_crc_byte u_crc (
        .crc_in  (crc_base),
        .data_in (in_byte_reg),
        .crc_out (crc_step)
    );

    always_comb begin
        hold_next = hold_base;
        src_next  = src_base;
        cmd_next  = cmd_base;
        hit       = 1'b0;
        hit_code  = ffcrc_pkg::ERR_OK;
        unique case (pos)
            ffcrc_pkg::POS_HEADER_HI, ffcrc_pkg::POS_TAIL_HI, ffcrc_pkg::POS_CRC_HI: begin
                hold_next = in_byte_reg;
            end
            ffcrc_pkg::POS_HEADER_LO: begin
                hit      = (word != header_word_reg);
                hit_code = ffcrc_pkg::ERR_HEADER;
            end
            ffcrc_pkg::POS_SOURCE: begin
                src_next = in_byte_reg;
            end
            ffcrc_pkg::POS_DEST: begin
                hit      = (in_byte_reg != own_id_reg);
                hit_code = ffcrc_pkg::ERR_DEST;
            end
            ffcrc_pkg::POS_CMD_LO: begin
                cmd_next = in_byte_reg & ffcrc_pkg::LOW_BYTE;
            end
            ffcrc_pkg::POS_TAIL_LO: begin
                hit      = (word != tail_word_reg);
                hit_code = ffcrc_pkg::ERR_TAIL;
            end
            ffcrc_pkg::FRAME_LAST: begin
                hit      = (word != crc_base);
                hit_code = ffcrc_pkg::ERR_CRC;
            end
            default: ;
        endcase
        err_new  = (err_base == ffcrc_pkg::ERR_OK && hit) ? hit_code : err_base;
        crc_next = (pos <= ffcrc_pkg::POS_CRC_END) ? crc_step : crc_base;
        pos_next = pos + 1'b1;
        err_next = err_new;
    end

    assign ok     = (err_new == ffcrc_pkg::ERR_OK);
    assign cmd_ok = ok && (src_base == main_id_reg);

    // frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= ffcrc_pkg::POS_HEADER_HI;
            crc_reg  <= ffcrc_pkg::CRC_INIT;
            hold_reg <= '0;
            err_reg  <= ffcrc_pkg::ERR_OK;
            src_reg  <= '0;
            cmd_reg  <= '0;
        end else if (work_fire) begin
            if (last) begin
                pos_reg  <= ffcrc_pkg::POS_HEADER_HI;
                crc_reg  <= ffcrc_pkg::CRC_INIT;
                hold_reg <= '0;
                err_reg  <= ffcrc_pkg::ERR_OK;
                src_reg  <= '0;
                cmd_reg  <= '0;
            end else begin
                pos_reg  <= pos_next;
                crc_reg  <= crc_next;
                hold_reg <= hold_next;
                err_reg  <= err_next;
                src_reg  <= src_next;
                cmd_reg  <= cmd_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (work_fire && last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (work_fire && last) begin
            ok_reg      <= ok;
            code_reg    <= err_new;
            src_out_reg <= src_base;
            cmd_ok_reg  <= cmd_ok;
            cmd_out_reg <= cmd_ok ? cmd_base : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_ok      = ok_reg;
    assign m_error_code    = code_reg;
    assign m_source_id     = src_out_reg;
    assign m_command_valid = cmd_ok_reg;
    assign m_command_value = cmd_out_reg;

endmodule

// ===== hw/rtl/ffcrc_checker.sv =====
// Port-level assertions for the frame checker, bound to the top level.
module ffcrc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_frame_ok,
    input logic [2:0]                   m_error_code,
    input logic [ffcrc_pkg::BYTE_W-1:0] m_source_id,
    input logic                         m_command_valid,
    input logic [ffcrc_pkg::BYTE_W-1:0] m_command_value
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("verdict valid straight after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_ok) && $stable(m_error_code)
            && $stable(m_source_id) && $stable(m_command_valid)
            && $stable(m_command_value))
        else $error("stalled verdict changed");

    a_ok_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_ok == (m_error_code == ffcrc_pkg::ERR_OK))
            && (m_error_code <= ffcrc_pkg::ERR_CRC))
        else $error("frame_ok and error code disagree");

    a_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_command_valid || m_frame_ok)
            && (m_command_valid || m_command_value == '0))
        else $error("command fields inconsistent with verdict");

endmodule

bind fixed_frame_crc16_checker ffcrc_checker u_ffcrc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_frame_ok      (m_frame_ok),
    .m_error_code    (m_error_code),
    .m_source_id     (m_source_id),
    .m_command_valid (m_command_valid),
    .m_command_value (m_command_value)
);
